// ===== src/tgf_pkg.sv =====
// Package for the grouped FIFO unit: widths, codes and shared types.
`timescale 1ns / 1ps
`default_nettype none
package tgf_pkg;
	localparam int MEMBER_W = 10;
	localparam int MEMBERS  = 1 << MEMBER_W;
	localparam int TEAM_W   = 4;
	localparam int TEAMS    = 1 << TEAM_W;
	localparam int SLOT_W   = 8;
	localparam int SLOTS    = 1 << SLOT_W;

	typedef enum logic [1:0] {
		KIND_ASSIGN  = 2'd0,
		KIND_ENQUEUE = 2'd1,
		KIND_DEQUEUE = 2'd2,
		KIND_CLEAR   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		STAT_DONE  = 2'd0,
		STAT_DEQD  = 2'd1,
		STAT_EMPTY = 2'd2,
		STAT_FULL  = 2'd3
	} status_t;

	typedef struct packed {
		kind_t               kind;
		logic [MEMBER_W-1:0] member;
		logic [TEAM_W-1:0]   team;
	} op_t;

	typedef struct packed {
		logic s1_valid;
		logic sweep_busy;
	} front_stat_t;
endpackage
`default_nettype wire

// ===== src/tgf_if.sv =====
// Request and result channel interfaces.
`timescale 1ns / 1ps
`default_nettype none
interface tgf_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [9:0] member;
	logic [3:0] team;
	modport source (output valid, kind, member, team, input ready);
	modport sink (input valid, kind, member, team, output ready);
endinterface

interface tgf_out_if;
	logic       valid;
	logic       ready;
	logic [9:0] member_out;
	logic [1:0] status;
	modport source (output valid, member_out, status, input ready);
	modport sink (input valid, member_out, status, output ready);
endinterface
`default_nettype wire

// ===== src/team_grouped_fifo_unit.sv =====
// Top level of the grouped FIFO unit.
// channel  dir  payload
// in_ch    in   kind, member, team
// out_ch   out  member_out, status
// Assign, clear, full and empty-dequeue requests finish in the idle state;
// enqueue and dequeue read first, then update the link and slot memories in ST_ENQ/ST_DEQ.
// After reset the team map is swept to zero, all 1024 entries, with in_ch.ready low.
// A two-entry queue lets the front keep taking requests while the back stalls.
`timescale 1ns / 1ps
`default_nettype none
module team_grouped_fifo_unit import tgf_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	tgf_in_if.sink    in_ch,
	tgf_out_if.source out_ch
);
	logic        f_valid;
	op_t         f_op;
	logic        q_not_full;
	logic        q_valid;
	op_t         q_op;
	logic        q_pop;
	front_stat_t f_stat;

	tgf_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.op_valid (f_valid),
		.op       (f_op),
		.op_ready (q_not_full),
		.stat     (f_stat)
	);

	tgf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (f_valid),
		.push_op   (f_op),
		.not_full  (q_not_full),
		.pop_valid (q_valid),
		.pop_op    (q_op),
		.pop       (q_pop)
	);

	tgf_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_valid (q_valid),
		.op       (q_op),
		.op_pop   (q_pop),
		.out_ch   (out_ch)
	);

	a_sweep_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		f_stat.sweep_busy |-> (!out_ch.valid && !in_ch.ready && !f_stat.s1_valid))
		else $error("activity during map sweep");
	a_front_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(f_stat.s1_valid && !q_not_full) |-> !in_ch.ready)
		else $error("request taken while front stage blocked");
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("pop from empty queue");
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && q_op.kind == KIND_CLEAR) |=> (out_ch.valid && out_ch.status == STAT_DONE))
		else $error("clear gave no done result");
endmodule
`default_nettype wire

// ===== src/tgf_front.sv =====
// Front end: accepts requests, keeps the member-to-team map, resolves teams.
`timescale 1ns / 1ps
`default_nettype none
module tgf_front import tgf_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	tgf_in_if.sink       in_ch,
	output logic         op_valid,
	output op_t          op,
	input  wire logic    op_ready,
	output front_stat_t stat
);
	logic [TEAM_W-1:0]   map_mem [MEMBERS];
	logic [TEAM_W-1:0]   map_rd_q;
	logic [MEMBER_W:0]   sweep_q;
	logic                s1_valid_q;
	op_t                 op_s1;
	logic                sweep_busy;
	logic                accept;

	assign sweep_busy  = !sweep_q[MEMBER_W];
	assign in_ch.ready = !sweep_busy && (!s1_valid_q || op_ready);
	assign accept      = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q    <= '0;
			s1_valid_q <= 1'b0;
		end else begin
			if (sweep_busy)
				sweep_q <= sweep_q + 1'b1;
			if (accept)
				s1_valid_q <= 1'b1;
			else if (op_ready)
				s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sweep_busy)
			map_mem[sweep_q[MEMBER_W-1:0]] <= '0;
		else if (accept && kind_t'(in_ch.kind) == KIND_ASSIGN)
			map_mem[in_ch.member] <= in_ch.team;
		if (accept) begin
			map_rd_q     <= map_mem[in_ch.member];
			op_s1.kind   <= kind_t'(in_ch.kind);
			op_s1.member <= in_ch.member;
			op_s1.team   <= in_ch.team;
		end
	end

	always_comb begin
		op = op_s1;
		if (op_s1.kind == KIND_ENQUEUE)
			op.team = map_rd_q;
	end

	assign op_valid        = s1_valid_q;
	assign stat.s1_valid   = s1_valid_q;
	assign stat.sweep_busy = sweep_busy;
endmodule
`default_nettype wire

// ===== src/tgf_queue.sv =====
// Two-entry request queue between front and back.
`timescale 1ns / 1ps
`default_nettype none
module tgf_queue import tgf_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  op_t       push_op,
	output logic      not_full,
	output logic      pop_valid,
	output op_t       pop_op,
	input  wire logic pop
);
	op_t        ent_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       do_push;
	logic       do_pop;

	assign not_full  = cnt_q != 2'd2;
	assign pop_valid = cnt_q != 2'd0;
	assign pop_op    = ent_q[rd_q];
	assign do_push   = push && not_full;
	assign do_pop    = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wr_q <= !wr_q;
			if (do_pop)
				rd_q <= !rd_q;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 2'd1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			ent_q[wr_q] <= push_op;
	end
endmodule
`default_nettype wire

// ===== src/tgf_back.sv =====
// Back end: team FIFOs, order ring, slot pool and result register.
`timescale 1ns / 1ps
`default_nettype none
module tgf_back import tgf_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic op_valid,
	input  op_t       op,
	output logic      op_pop,
	tgf_out_if.source out_ch
);
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_ENQ  = 3'b010,
		ST_DEQ  = 3'b100
	} state_t;

	state_t              state_q;
	logic [MEMBER_W-1:0] slot_member [SLOTS];
	logic [SLOT_W-1:0]   slot_next [SLOTS];
	logic [SLOT_W-1:0]   free_stack [SLOTS];
	logic [SLOT_W-1:0]   head_q [TEAMS];
	logic [SLOT_W-1:0]   tail_q [TEAMS];
	logic [TEAM_W-1:0]   ring_q [TEAMS];
	logic [TEAMS-1:0]    nonempty_q;
	logic [SLOT_W:0]     free_cnt_q;
	logic [SLOT_W:0]     low_q;
	logic [TEAM_W-1:0]   ord_head_q;
	logic [TEAM_W:0]     ord_cnt_q;
	logic [MEMBER_W-1:0] sm_rd_q;
	logic [SLOT_W-1:0]   sn_rd_q;
	logic [SLOT_W-1:0]   fs_rd_q;
	logic [TEAM_W-1:0]   t_q;
	logic [MEMBER_W-1:0] m_q;
	logic [SLOT_W-1:0]   slot_q;
	logic                fresh_q;
	logic                out_valid_q;
	logic [MEMBER_W-1:0] out_member_q;
	status_t             out_status_q;
	logic                out_free;
	logic [SLOT_W:0]     fc_dec;
	logic [TEAM_W-1:0]   deq_team;
	logic [SLOT_W-1:0]   deq_slot;
	logic [SLOT_W-1:0]   enq_slot;
	logic                start_enq;
	logic                start_deq;
	logic                fin_enq;
	logic                fin_deq;
	logic                res_done;

	assign out_free  = !out_valid_q || out_ch.ready;
	assign op_pop    = op_valid && state_q == ST_IDLE && out_free;
	assign fc_dec    = free_cnt_q - 1'b1;
	assign deq_team  = ring_q[ord_head_q];
	assign deq_slot  = head_q[deq_team];
	assign enq_slot  = fresh_q ? slot_q : fs_rd_q;
	assign start_enq = op_pop && op.kind == KIND_ENQUEUE && free_cnt_q != '0;
	assign start_deq = op_pop && op.kind == KIND_DEQUEUE && ord_cnt_q != '0;
	assign fin_enq   = state_q == ST_ENQ && out_free;
	assign fin_deq   = state_q == ST_DEQ && out_free;
	assign res_done  = (op_pop && !start_enq && !start_deq) || fin_enq || fin_deq;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			nonempty_q  <= '0;
			free_cnt_q  <= (SLOT_W+1)'(SLOTS);
			low_q       <= (SLOT_W+1)'(SLOTS);
			ord_head_q  <= '0;
			ord_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (res_done)
				out_valid_q <= 1'b1;
			else if (out_ch.ready)
				out_valid_q <= 1'b0;
			case (state_q)
			ST_IDLE: begin
				if (op_pop) begin
					case (op.kind)
					KIND_ENQUEUE: begin
						if (start_enq) begin
							free_cnt_q <= fc_dec;
							if (fc_dec < low_q)
								low_q <= fc_dec;
							state_q <= ST_ENQ;
						end
					end
					KIND_DEQUEUE: begin
						if (start_deq)
							state_q <= ST_DEQ;
					end
					KIND_CLEAR: begin
						nonempty_q <= '0;
						free_cnt_q <= (SLOT_W+1)'(SLOTS);
						low_q      <= (SLOT_W+1)'(SLOTS);
						ord_head_q <= '0;
						ord_cnt_q  <= '0;
					end
					default: ;
					endcase
				end
			end
			ST_ENQ: begin
				if (fin_enq) begin
					if (!nonempty_q[t_q]) begin
						nonempty_q[t_q] <= 1'b1;
						ord_cnt_q       <= ord_cnt_q + 1'b1;
					end
					state_q <= ST_IDLE;
				end
			end
			ST_DEQ: begin
				if (fin_deq) begin
					free_cnt_q <= free_cnt_q + 1'b1;
					if (tail_q[t_q] == slot_q) begin
						nonempty_q[t_q] <= 1'b0;
						ord_head_q      <= ord_head_q + 1'b1;
						ord_cnt_q       <= ord_cnt_q - 1'b1;
					end
					state_q <= ST_IDLE;
				end
			end
			default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start_enq) begin
			fs_rd_q <= free_stack[fc_dec[SLOT_W-1:0]];
			slot_q  <= fc_dec[SLOT_W-1:0];
			fresh_q <= fc_dec < low_q;
			t_q     <= op.team;
			m_q     <= op.member;
		end
		if (start_deq) begin
			sm_rd_q <= slot_member[deq_slot];
			sn_rd_q <= slot_next[deq_slot];
			slot_q  <= deq_slot;
			t_q     <= deq_team;
		end
		if (fin_enq) begin
			slot_member[enq_slot] <= m_q;
			if (nonempty_q[t_q])
				slot_next[tail_q[t_q]] <= enq_slot;
			else begin
				head_q[t_q] <= enq_slot;
				ring_q[ord_head_q + ord_cnt_q[TEAM_W-1:0]] <= t_q;
			end
			tail_q[t_q] <= enq_slot;
		end
		if (fin_deq) begin
			free_stack[free_cnt_q[SLOT_W-1:0]] <= slot_q;
			if (tail_q[t_q] != slot_q)
				head_q[t_q] <= sn_rd_q;
		end
		if (op_pop) begin
			out_member_q <= '0;
			case (op.kind)
			KIND_ENQUEUE: out_status_q <= start_enq ? STAT_DONE : STAT_FULL;
			KIND_DEQUEUE: out_status_q <= start_deq ? STAT_DEQD : STAT_EMPTY;
			default:      out_status_q <= STAT_DONE;
			endcase
		end
		if (fin_deq)
			out_member_q <= sm_rd_q;
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.member_out = out_member_q;
	assign out_ch.status     = out_status_q;
endmodule
`default_nettype wire
